/* rtl/smld_pkg.sv */
// ----------------------------------------------------------------------------
// smld_pkg: shared types and constants of the start/mode/length deframer
//
// Holds the queued result entry, the front-to-queue and queue-to-back
// control groups, the parser phase codes and the register map.
// ----------------------------------------------------------------------------
`default_nettype none

package smld_pkg;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  // Register map, in byte addresses.
  localparam logic [CFG_ADDR_W-1:0] REG_START_BYTE = 2'd0;

  // Result kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  // Depth of the queue between the parser and the output stage.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Parser phases, one-hot.
  typedef enum logic [5:0] {
    PH_HUNT    = 6'b000001,
    PH_MODE    = 6'b000010,
    PH_LEN     = 6'b000100,
    PH_PAYLOAD = 6'b001000,
    PH_END     = 6'b010000,
    PH_CLOSE   = 6'b100000
  } smld_phase_t;

  // One result as it waits in the queue.
  typedef struct packed {
    logic        kind;
    logic [7:0]  mode;
    logic [7:0]  data;
    logic [31:0] length;
  } smld_res_t;

  // Parser to queue.
  typedef struct packed {
    logic      push;
    smld_res_t res;
  } smld_push_t;

  // Queue head to output stage.
  typedef struct packed {
    logic      valid;
    smld_res_t res;
  } smld_head_t;

endpackage

`default_nettype wire

/* rtl/smld_if.sv */
// ----------------------------------------------------------------------------
// smld_if: valid/ready channels of the deframer
//
// smld_in_if carries received bytes in, smld_out_if carries results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface smld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source  (output valid, output rx_byte, input ready);
  modport sink    (input valid, input rx_byte, output ready);
  modport monitor (input valid, input rx_byte, input ready);
endinterface

interface smld_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  mode;
  logic [7:0]  payload_byte;
  logic [31:0] payload_length;
  logic        last;

  modport source  (output valid, output kind, output mode, output payload_byte,
                   output payload_length, output last, input ready);
  modport sink    (input valid, input kind, input mode, input payload_byte,
                   input payload_length, input last, output ready);
  modport monitor (input valid, input kind, input mode, input payload_byte,
                   input payload_length, input last, input ready);
endinterface

`default_nettype wire

/* rtl/smld_parser.sv */
// ----------------------------------------------------------------------------
// smld_parser: front end of the deframer
//
// Takes one byte per beat, tracks the frame phase and emits at most one
// result entry per accepted byte toward the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module smld_parser
  import smld_pkg::*;
#(
  parameter int START_LEN = 4,
  parameter int LEN_BYTES = 4,
  parameter int END_LEN   = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       acc,
  input  wire logic [7:0] rx_byte,
  input  wire logic [7:0] start_byte,
  output smld_push_t      push_o
);

  localparam int RUN_W = $clog2(START_LEN + 1);

  smld_phase_t        phase_r, phase_nxt;
  logic [RUN_W-1:0]   run_r, run_nxt;
  logic [7:0]         mode_r, mode_nxt;
  logic [31:0]        len_r, len_nxt;
  logic [31:0]        cnt_r, cnt_nxt;

  logic [RUN_W-1:0]   hunt_base;
  logic [RUN_W-1:0]   hunt_inc;
  logic               hunt_hit;
  logic               hunt_go;
  logic [31:0]        cnt_inc;
  logic [31:0]        len_acc;
  logic               res_vld;
  logic               res_kind;

  // A start run restarts from zero when a frame has just closed.
  assign hunt_base = (phase_r == PH_HUNT) ? run_r : '0;
  assign hunt_inc  = hunt_base + RUN_W'(1);
  assign hunt_hit  = (rx_byte == start_byte);
  assign hunt_go   = hunt_hit && (hunt_inc >= RUN_W'(START_LEN));
  assign cnt_inc   = cnt_r + 32'd1;
  assign len_acc   = len_r | (32'(rx_byte) << {cnt_r[1:0], 3'b000});

  always_comb begin
    phase_nxt = phase_r;
    run_nxt   = run_r;
    mode_nxt  = mode_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    res_vld   = 1'b0;
    res_kind  = KIND_PAYLOAD;
    unique case (phase_r)
      PH_MODE: begin
        mode_nxt  = rx_byte;
        len_nxt   = '0;
        cnt_nxt   = '0;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        len_nxt = len_acc;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= 32'(LEN_BYTES)) begin
          cnt_nxt = '0;
          if (len_acc != 32'd0) begin
            phase_nxt = PH_PAYLOAD;
          end else if (END_LEN == 0) begin
            phase_nxt = PH_HUNT;
            res_vld   = 1'b1;
            res_kind  = KIND_END;
          end else begin
            phase_nxt = PH_END;
          end
        end
      end
      PH_PAYLOAD: begin
        res_vld = 1'b1;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= len_r) begin
          cnt_nxt   = '0;
          phase_nxt = (END_LEN == 0) ? PH_CLOSE : PH_END;
        end
      end
      PH_END: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= 32'(END_LEN)) begin
          cnt_nxt   = '0;
          phase_nxt = PH_HUNT;
          res_vld   = 1'b1;
          res_kind  = KIND_END;
        end
      end
      default: begin
        // Hunting, and the closing beat that also hunts on its byte.
        if (phase_r == PH_CLOSE) begin
          res_vld  = 1'b1;
          res_kind = KIND_END;
        end
        if (hunt_hit) begin
          run_nxt   = hunt_go ? '0 : hunt_inc;
          phase_nxt = hunt_go ? PH_MODE : PH_HUNT;
        end else begin
          run_nxt   = '0;
          phase_nxt = PH_HUNT;
        end
      end
    endcase
  end

  always_comb begin
    push_o.push       = acc && res_vld;
    push_o.res.kind   = res_kind;
    push_o.res.mode   = mode_r;
    push_o.res.data   = rx_byte;
    push_o.res.length = len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      run_r   <= '0;
      mode_r  <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      run_r   <= run_nxt;
      mode_r  <= mode_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/smld_queue.sv */
// ----------------------------------------------------------------------------
// smld_queue: short result queue between parser and output stage
//
// Two-entry FIFO; lets the parser keep taking bytes while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module smld_queue
  import smld_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  smld_push_t push_i,
  input  wire logic  pop,
  output smld_head_t head_o,
  output logic       has_room
);

  smld_res_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign has_room     = (cnt_r < QCNT_W'(QDEPTH));
  assign head_o.valid = (cnt_r != '0);
  assign head_o.res   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_i.push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push_i.push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push_i.push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push_i.push) begin
      mem_r[wr_ptr_r] <= push_i.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/smld_out.sv */
// ----------------------------------------------------------------------------
// smld_out: back end of the deframer
//
// Pulls entries from the queue, formats them into result fields and holds
// them in the output register until the sink takes the beat.
// ----------------------------------------------------------------------------
`default_nettype none

module smld_out
  import smld_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  smld_head_t  head_i,
  output logic        pop,
  smld_out_if.source  out_ch
);

  logic        vld_r;
  logic        kind_r;
  logic [7:0]  mode_r;
  logic [7:0]  byte_r;
  logic [31:0] len_r;

  assign pop = head_i.valid && (!vld_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!vld_r || out_ch.ready) begin
      vld_r <= head_i.valid;
    end
  end

  // Payload bytes carry no length; packet ends carry no byte.
  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r <= head_i.res.kind;
      mode_r <= head_i.res.mode;
      byte_r <= (head_i.res.kind == KIND_END) ? 8'd0 : head_i.res.data;
      len_r  <= (head_i.res.kind == KIND_END) ? head_i.res.length : 32'd0;
    end
  end

  assign out_ch.valid          = vld_r;
  assign out_ch.kind           = kind_r;
  assign out_ch.mode           = mode_r;
  assign out_ch.payload_byte   = byte_r;
  assign out_ch.payload_length = len_r;
  assign out_ch.last           = (kind_r == KIND_END);

endmodule

`default_nettype wire

/* rtl/start_mode_length_deframer.sv */
// ----------------------------------------------------------------------------
// start_mode_length_deframer: start-run / mode / length packet deframer
//
// Finds framed packets in a byte stream and passes their payload out.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock cycle, with no bubbles, for as
// long as the result side keeps up. Each frame opens with START_LEN bytes equal
// to the start_byte register, followed by a mode byte and a LEN_BYTES length,
// least significant byte first. Every payload byte leaves as one result beat
// tagged with the mode, then END_LEN trailing bytes are skipped unchecked and a
// packet-end beat carries the mode and declared length with last set. A zero
// length gives just the packet-end beat. When END_LEN is zero the packet-end
// beat comes on the byte after the last payload byte, and that byte also counts
// toward the next start run. At the edge that accepts a byte, the parser
// writes its result into a two-entry queue, and the output stage registers it
// from there once its output register is free, then offers it on the output.
// The input stays ready while the queue has room, so a stalled output first
// fills the output register and then the queue before the input is held off.
// The start_byte register lives at byte address 0 of the APB port and should be
// written only while no frame is in flight; it is read back on the same port.
// ----------------------------------------------------------------------------
`default_nettype none

module start_mode_length_deframer
  import smld_pkg::*;
#(
  parameter int START_LEN = 4,
  parameter int LEN_BYTES = 4,
  parameter int END_LEN   = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  smld_in_if.sink                    in_ch,
  smld_out_if.source                 out_ch,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  logic [7:0] start_byte_r;
  logic       in_acc;
  logic       q_room;
  logic       q_pop;
  smld_push_t push;
  smld_head_t head;

  // Configuration: the register is written in the access phase of a write.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_START_BYTE) ? CFG_DATA_W'(start_byte_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_START_BYTE) begin
      start_byte_r <= cfg_pwdata[7:0];
    end
  end

  // A byte is taken whenever the queue can hold the result it might make.
  assign in_ch.ready = q_room;
  assign in_acc      = in_ch.valid && q_room;

  smld_parser #(
    .START_LEN (START_LEN),
    .LEN_BYTES (LEN_BYTES),
    .END_LEN   (END_LEN)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (in_acc),
    .rx_byte    (in_ch.rx_byte),
    .start_byte (start_byte_r),
    .push_o     (push)
  );

  smld_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_i   (push),
    .pop      (q_pop),
    .head_o   (head),
    .has_room (q_room)
  );

  smld_out u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .head_i (head),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

/* rtl/smld_chk.sv */
// ----------------------------------------------------------------------------
// smld_chk: port-level checks of the deframer
//
// Watches the top-level ports only and is bound onto the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module smld_chk
  import smld_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_ready,
  input  wire logic                  out_valid,
  input  wire logic                  out_ready,
  input  wire logic                  out_kind,
  input  wire logic [7:0]            out_mode,
  input  wire logic [7:0]            out_payload_byte,
  input  wire logic [31:0]           out_payload_length,
  input  wire logic                  out_last,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  input  wire logic [CFG_DATA_W-1:0] cfg_prdata
);

  // A stalled result beat holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload_byte)
      && $stable(out_payload_length) && $stable(out_kind) && $stable(out_mode))
    else $error("result beat changed while stalled");

  // Nothing is offered on the cycle after reset, and the input is open.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("result offered or input held off right after reset");

  // A start byte write reads back on the next cycle.
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_START_BYTE
      |=> cfg_paddr != REG_START_BYTE || cfg_prdata[7:0] == $past(cfg_pwdata[7:0]))
    else $error("start byte readback mismatch");

  // Payload beats carry no length or end mark; end beats carry no byte.
  a_kind_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_END && out_last && out_payload_byte == 8'd0)
      || (out_kind == KIND_PAYLOAD && !out_last && out_payload_length == 32'd0))
    else $error("result fields do not match kind");

endmodule

bind start_mode_length_deframer smld_chk u_smld_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_kind           (out_ch.kind),
  .out_mode           (out_ch.mode),
  .out_payload_byte   (out_ch.payload_byte),
  .out_payload_length (out_ch.payload_length),
  .out_last           (out_ch.last),
  .cfg_psel           (cfg_psel),
  .cfg_penable        (cfg_penable),
  .cfg_pwrite         (cfg_pwrite),
  .cfg_paddr          (cfg_paddr),
  .cfg_pwdata         (cfg_pwdata),
  .cfg_prdata         (cfg_prdata)
);

`default_nettype wire
